FILE: hw/rtl/rcsp_pkg.sv
// Package for the rule chain shortest path block.
// Holds sizes, codes, request/response payload types and small helpers.
// No dependencies; compile first.
`default_nettype none

package rcsp_pkg;

    localparam int MAX_RULES = 16;
    localparam int ADDR_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_RULES);
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int NUM_W     = 5;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // Status codes of a response.
    typedef enum logic [2:0] {
        STS_LOADED  = 3'd0,
        STS_FULL    = 3'd1,
        STS_CLEARED = 3'd2,
        STS_STEP    = 3'd3,
        STS_NOPATH  = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_PICK,
        ST_CHK,
        ST_INNER,
        ST_WALK,
        ST_WALK_RD,
        ST_EMIT
    } t_state;

    // One stored rule.
    typedef struct packed {
        logic [ADDR_BITS-1:0] src;
        logic                 any;
        logic [ADDR_BITS-1:0] dst;
        logic                 allow;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    typedef struct packed {
        logic [1:0]           operation;
        logic [ADDR_BITS-1:0] source_address;
        logic                 source_any;
        logic [ADDR_BITS-1:0] destination_address;
        logic                 allow;
        logic [ADDR_BITS-1:0] start_address;
        logic [ADDR_BITS-1:0] end_address;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [NUM_W-1:0] rule_number;
        logic             last;
    } t_rsp;

    // Index of the lowest set bit; zero when the mask is empty.
    function automatic logic [IDX_W-1:0] lowest(input logic [MAX_RULES-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = MAX_RULES - 1; k >= 0; k--) begin
            if (mask[k]) begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rcsp_chan_if.sv
// Request and response channel interfaces of the rule chain search block.
// Depends on rcsp_pkg for the payload types.
`default_nettype none

interface rcsp_req_if;
    logic              valid;
    logic              ready;
    rcsp_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcsp_rsp_if;
    logic              valid;
    logic              ready;
    rcsp_pkg::t_rsp    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rcsp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rule_chain_shortest_path.sv
// Top level of the rule chain shortest path block.
// Depends on rcsp_pkg, rcsp_chan_if and rcsp_ram.
//
//  Port     Dir  Carries
//  i_req    in   operation, rule fields, start and end addresses
//  o_rsp    out  status, rule_number, last
//
// Clear and load are answered from the response register in the cycle after
// they are accepted. A search first reads every loaded rule to collect seeds,
// then reads and expands each frontier rule level by level, and finally walks
// the parent links back and emits the chain; its speed is set by the single
// read port of the rule RAM (one rule per cycle). Reset clears the rule count
// and the sequencer. A new request is taken only when idle and the response
// register is empty; a stalled response holds the sequencer.
`default_nettype none

module rule_chain_shortest_path (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcsp_req_if.sink   i_req,
    rcsp_rsp_if.source o_rsp
);
    import rcsp_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_j, n_j;
    logic [MAX_RULES-1:0]  r_exact, n_exact, r_anym, n_anym;
    logic [MAX_RULES-1:0]  r_visited, n_visited, r_pend, n_pend;
    logic [MAX_RULES-1:0]  r_next, n_next, r_seed, n_seed;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [ADDR_BITS-1:0]  r_dst, n_dst, r_start, n_start, r_goal, n_goal;
    logic [IDX_W-1:0]      r_chain [MAX_RULES];
    logic [IDX_W-1:0]      n_chain [MAX_RULES];
    logic [CNT_W-1:0]      r_len, n_len;
    logic                  r_out_vld, n_out_vld;
    t_rsp                  r_out, n_out;

    logic                  tbl_we;
    logic [IDX_W-1:0]      tbl_waddr, tbl_raddr;
    t_rule                 tbl_wdata, tbl_rdata;
    logic                  par_we;
    logic [IDX_W-1:0]      par_waddr, par_raddr, par_rdata;

    logic                  out_free;
    logic [IDX_W-1:0]      k_idx;
    logic [MAX_RULES-1:0]  v_exact, v_anym, v_seeds;

    // Rule table and parent links.
    rcsp_ram #(.WIDTH(RULE_W), .DEPTH(MAX_RULES)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    rcsp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RULES)) u_par (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (r_cur),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    assign out_free      = !r_out_vld || o_rsp.ready;
    assign i_req.ready   = (r_state == ST_IDLE) && !r_out_vld;
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.data    = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // Search working registers.
    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_exact   <= n_exact;
        r_anym    <= n_anym;
        r_visited <= n_visited;
        r_pend    <= n_pend;
        r_next    <= n_next;
        r_seed    <= n_seed;
        r_cur     <= n_cur;
        r_dst     <= n_dst;
        r_start   <= n_start;
        r_goal    <= n_goal;
        r_chain   <= n_chain;
        r_len     <= n_len;
        r_out     <= n_out;
    end

    // Sequencer: next state, RAM accesses and responses.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_exact   = r_exact;
        n_anym    = r_anym;
        n_visited = r_visited;
        n_pend    = r_pend;
        n_next    = r_next;
        n_seed    = r_seed;
        n_cur     = r_cur;
        n_dst     = r_dst;
        n_start   = r_start;
        n_goal    = r_goal;
        n_chain   = r_chain;
        n_len     = r_len;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_rsp.ready;

        tbl_we    = 1'b0;
        tbl_waddr = r_count[IDX_W-1:0];
        tbl_wdata.src   = i_req.data.source_address;
        tbl_wdata.any   = i_req.data.source_any;
        tbl_wdata.dst   = i_req.data.destination_address;
        tbl_wdata.allow = i_req.data.allow;
        tbl_raddr = r_j[IDX_W-1:0];
        par_we    = 1'b0;
        par_waddr = r_j[IDX_W-1:0];
        par_raddr = r_cur;
        k_idx     = IDX_W'(r_j - CNT_W'(1));
        v_exact   = r_exact;
        v_anym    = r_anym;
        v_seeds   = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_out.rule_number = '0;
                    n_out.last        = 1'b1;
                    case (i_req.data.operation)
                        OP_CLEAR: begin
                            n_count      = '0;
                            n_out.status = STS_CLEARED;
                            n_out_vld    = 1'b1;
                        end
                        OP_LOAD: begin
                            if (r_count == CNT_W'(MAX_RULES)) begin
                                n_out.status = STS_FULL;
                            end else begin
                                tbl_we       = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                n_out.status = STS_LOADED;
                            end
                            n_out_vld = 1'b1;
                        end
                        OP_SEARCH: begin
                            n_start = i_req.data.start_address;
                            n_goal  = i_req.data.end_address;
                            n_j     = '0;
                            n_exact = '0;
                            n_anym  = '0;
                            n_state = ST_SEED;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Read every rule once and collect both seed sets.
            ST_SEED: begin
                if (r_j != '0) begin
                    if (tbl_rdata.allow && !tbl_rdata.any && tbl_rdata.src == r_start) begin
                        v_exact[k_idx] = 1'b1;
                    end
                    if (tbl_rdata.allow && tbl_rdata.any) begin
                        v_anym[k_idx] = 1'b1;
                    end
                end
                n_exact = v_exact;
                n_anym  = v_anym;
                if (r_j == r_count) begin
                    v_seeds   = (v_exact != '0) ? v_exact : v_anym;
                    n_visited = v_seeds;
                    n_pend    = v_seeds;
                    n_seed    = v_seeds;
                    n_next    = '0;
                    n_state   = ST_PICK;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end

            // Take the lowest pending frontier rule, or advance a level.
            ST_PICK: begin
                if (r_pend != '0) begin
                    n_cur           = lowest(r_pend);
                    tbl_raddr       = n_cur;
                    n_pend[n_cur]   = 1'b0;
                    n_state         = ST_CHK;
                end else if (r_next != '0) begin
                    n_pend = r_next;
                    n_next = '0;
                end else if (out_free) begin
                    n_out.status      = STS_NOPATH;
                    n_out.rule_number = '0;
                    n_out.last        = 1'b1;
                    n_out_vld         = 1'b1;
                    n_state           = ST_IDLE;
                end
            end

            // Goal test on the frontier rule, else start its expansion.
            ST_CHK: begin
                n_dst = tbl_rdata.dst;
                if (tbl_rdata.dst == r_goal) begin
                    n_len   = '0;
                    n_state = ST_WALK;
                end else begin
                    n_j       = '0;
                    tbl_raddr = '0;
                    n_state   = ST_INNER;
                end
            end

            // Mark unvisited allow rules that can follow the current one.
            ST_INNER: begin
                tbl_raddr = IDX_W'(r_j + CNT_W'(1));
                if (tbl_rdata.allow && !r_visited[r_j[IDX_W-1:0]]
                        && (tbl_rdata.any || tbl_rdata.src == r_dst)) begin
                    n_visited[r_j[IDX_W-1:0]] = 1'b1;
                    n_next[r_j[IDX_W-1:0]]    = 1'b1;
                    par_we                    = 1'b1;
                end
                if (r_j == r_count - CNT_W'(1)) begin
                    n_state = ST_PICK;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end

            // Follow parent links back to a seed, stacking the chain.
            ST_WALK: begin
                for (int k = MAX_RULES - 1; k > 0; k--) begin
                    n_chain[k] = r_chain[k-1];
                end
                n_chain[0] = r_cur;
                n_len      = r_len + CNT_W'(1);
                if (r_seed[r_cur]) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_WALK_RD;
                end
            end

            ST_WALK_RD: begin
                n_cur   = par_rdata;
                n_state = ST_WALK;
            end

            // Emit the chain from the seed to the goal rule.
            ST_EMIT: begin
                if (out_free) begin
                    n_out.status      = STS_STEP;
                    n_out.rule_number = NUM_W'(r_chain[0]) + NUM_W'(1);
                    n_out.last        = (r_len == CNT_W'(1));
                    n_out_vld         = 1'b1;
                    for (int k = 0; k < MAX_RULES - 1; k++) begin
                        n_chain[k] = r_chain[k+1];
                    end
                    n_len = r_len - CNT_W'(1);
                    if (r_len == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Rule count never passes the table depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RULES))
        else $error("rule count above table depth");

    // Every pending frontier rule has been marked visited.
    a_pend_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK || r_state == ST_CHK || r_state == ST_INNER)
            |-> ((r_pend & ~r_visited) == '0))
        else $error("frontier rule not visited");

    // A chain being emitted holds at least one rule.
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_len != '0 && r_len <= CNT_W'(MAX_RULES)))
        else $error("chain length out of range");

    // A final path step returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_len == CNT_W'(1)) |=> (r_state == ST_IDLE))
        else $error("sequencer did not finish after last step");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for the rule chain shortest path block: loads rule tables, runs searches
// and compares each response against a predictor of the breadth-first search.
// Depends on rcsp_pkg, rcsp_chan_if and the rule_chain_shortest_path RTL.
`default_nettype none

module tb;
    import rcsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int REQ_W = $bits(t_req);

    logic i_clk;
    logic i_rst_n;

    rcsp_req_if req_ch ();
    rcsp_rsp_if rsp_ch ();

    rule_chain_shortest_path dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predictor state: the rule table as the block should hold it.
    t_rule rules_q [MAX_RULES];
    int    rule_total;
    t_rsp  pending_rsp [$];

    int error_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic push_rsp(input t_status sts, input int num, input logic fin);
        t_rsp r;
        r.status = sts;
        r.rule_number = NUM_W'(num);
        r.last = fin;
        pending_rsp.insert(pending_rsp.size(), r);
    endtask

    // Breadth-first search over the predicted table; queues the chain or no path.
    task automatic predict_search(input logic [ADDR_BITS-1:0] start_a,
                                  input logic [ADDR_BITS-1:0] goal_a);
        logic [MAX_RULES-1:0] seeds, seen, front, nxt;
        int par [MAX_RULES];
        int chain [$];
        int found, cur;
        seeds = '0;
        found = -1;
        for (int i = 0; i < rule_total; i++)
            if (rules_q[i].allow && !rules_q[i].any && rules_q[i].src == start_a) seeds[i] = 1'b1;
        if (seeds == '0)
            for (int i = 0; i < rule_total; i++)
                if (rules_q[i].allow && rules_q[i].any) seeds[i] = 1'b1;
        seen = seeds;
        front = seeds;
        for (int i = 0; i < MAX_RULES; i++) par[i] = 0;
        while (front != '0 && found < 0) begin
            for (int i = 0; i < rule_total; i++)
                if (found < 0 && front[i] && rules_q[i].dst == goal_a) found = i;
            if (found >= 0) break;
            nxt = '0;
            for (int i = 0; i < rule_total; i++) begin
                if (!front[i]) continue;
                for (int j = 0; j < rule_total; j++) begin
                    if (!rules_q[j].allow || seen[j]) continue;
                    if (rules_q[j].any || rules_q[j].src == rules_q[i].dst) begin
                        seen[j] = 1'b1;
                        nxt[j] = 1'b1;
                        par[j] = i + 1;
                    end
                end
            end
            front = nxt;
        end
        if (found < 0) begin
            push_rsp(STS_NOPATH, 0, 1'b1);
        end else begin
            cur = found;
            forever begin
                chain.push_front(cur + 1);
                if (par[cur] == 0) break;
                cur = par[cur] - 1;
            end
            foreach (chain[k]) push_rsp(STS_STEP, chain[k], k == chain.size() - 1);
        end
    endtask

    // Works out the responses that one accepted request should cause.
    task automatic predict_request(input t_req rq);
        case (rq.operation)
            OP_CLEAR: begin
                rule_total = 0;
                push_rsp(STS_CLEARED, 0, 1'b1);
            end
            OP_LOAD: begin
                if (rule_total >= MAX_RULES) begin
                    push_rsp(STS_FULL, 0, 1'b1);
                end else begin
                    rules_q[rule_total].src = rq.source_address;
                    rules_q[rule_total].any = rq.source_any;
                    rules_q[rule_total].dst = rq.destination_address;
                    rules_q[rule_total].allow = rq.allow;
                    rule_total++;
                    push_rsp(STS_LOADED, 0, 1'b1);
                end
            end
            OP_SEARCH: predict_search(rq.start_address, rq.end_address);
            default: ;
        endcase
    endtask

    // Sends one request, with a random idle gap, and waits for its acceptance.
    // Valid stays high after acceptance until the next request or an idle gap.
    task automatic send_request(input t_req rq);
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(rq);
        @(negedge i_clk);
    endtask

    function automatic t_req make_load(input logic [ADDR_BITS-1:0] s, input logic any_s,
                                       input logic [ADDR_BITS-1:0] d, input logic alw);
        t_req rq;
        rq = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        rq.operation = OP_LOAD;
        rq.source_address = s;
        rq.source_any = any_s;
        rq.destination_address = d;
        rq.allow = alw;
        return rq;
    endfunction

    function automatic t_req make_op(input logic [1:0] op, input logic [ADDR_BITS-1:0] s,
                                     input logic [ADDR_BITS-1:0] g);
        t_req rq;
        rq = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        rq.operation = op;
        rq.start_address = s;
        rq.end_address = g;
        return rq;
    endfunction

    // Small address pool so that rules chain; sometimes an extreme word.
    function automatic logic [ADDR_BITS-1:0] pick_addr();
        case ($urandom_range(9))
            0: return '1;
            1: return $urandom;
            default: return ADDR_BITS'($urandom_range(5));
        endcase
    endfunction

    // Drops valid, waits until every expected response has arrived, then settles.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Extremes, wildcards, blocked rules, full table and empty-table search.
    task automatic test_directed();
        send_request(make_op(OP_SEARCH, 0, 0));
        send_request(make_op(2'd3, 0, 0));
        send_request(make_load('1, 1'b0, '0, 1'b1));
        send_request(make_load('0, 1'b0, 32'd7, 1'b1));
        send_request(make_load(32'd7, 1'b0, '1, 1'b1));
        send_request(make_load(32'd9, 1'b1, 32'd8, 1'b1));
        send_request(make_load('0, 1'b0, '1, 1'b0));
        send_request(make_op(OP_SEARCH, '0, '1));
        send_request(make_op(OP_SEARCH, 32'd5, 32'd8));
        send_request(make_op(OP_SEARCH, '1, 32'd123));
        send_request(make_op(OP_SEARCH, '1, 32'd8));
        for (int i = 0; i < 12; i++)
            send_request(make_load(ADDR_BITS'(i), 1'b0, ADDR_BITS'(i + 1), 1'b1));
        send_request(make_op(OP_SEARCH, 32'd1, 32'd11));
        send_request(make_op(OP_CLEAR, 0, 0));
        drain();
    endtask

    // Random tables, mostly small and sometimes overfilled, each followed by one to three requests, mostly searches.
    task automatic test_random(input int idle_p, input int stall_p, input int batches);
        int n;
        idle_pct = idle_p;
        stall_pct = stall_p;
        for (int b = 0; b < batches; b++) begin
            n = ($urandom_range(9) == 0) ? 17 : $urandom_range(1, 7);
            for (int i = 0; i < n; i++)
                send_request(make_load(pick_addr(), $urandom_range(5) == 0, pick_addr(),
                                       $urandom_range(4) != 0));
            repeat ($urandom_range(1, 3))
                send_request(make_op(($urandom_range(15) == 0) ? 2'd3 : OP_SEARCH,
                                     pick_addr(), pick_addr()));
            send_request(make_op(OP_CLEAR, 0, 0));
        end
        drain();
    endtask

    // Response checker with random back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with nothing expected");
            end else begin
                t_rsp exp_r;
                exp_r = pending_rsp.pop_front();
                if (rsp_ch.data.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_ch.data.status, exp_r.status));
                if (rsp_ch.data.rule_number !== exp_r.rule_number)
                    report_mismatch($sformatf("rule number %0d, expected %0d",
                                              rsp_ch.data.rule_number, exp_r.rule_number));
                if (rsp_ch.data.last !== exp_r.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              rsp_ch.data.last, exp_r.last));
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles without any accepted request or response.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        quiet_cycles = 0;
        rule_total = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(0, 0, 3);
        test_random(51, 0, 3);
        test_random(0, 51, 3);
        test_random(30, 30, 4);
        drain();
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
